/* rtl/core/pcdf_pkg.sv */
`timescale 1ns / 1ps

package pcdf_pkg;

  // Counter and arithmetic widths
  localparam int CNT_W      = 16;
  localparam int OUT_CNT_W  = 16;
  localparam int PRESCALE   = 8;
  localparam int PRE_W      = $clog2(PRESCALE + 1);
  localparam int DEN_W      = CNT_W + PRE_W;
  localparam int NUM_W      = 32;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int DUTY_W     = 8;
  localparam int PCT_SCALE  = 100;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  // Codes reported while busy or for a zero period
  localparam logic [DUTY_W-1:0] DUTY_NONE = 8'hFF;
  localparam logic [NUM_W-1:0]  FREQ_NONE = '1;

  // Request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Commands
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 1'd1;
  localparam logic [NUM_W-1:0]     NUMERATOR_RST = 32'd160000000;

  typedef struct packed {
    logic command;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic                 ready_res;
    logic [DUTY_W-1:0]    duty_percent;
    logic [NUM_W-1:0]     frequency;
    logic [OUT_CNT_W-1:0] high_counts;
    logic [OUT_CNT_W-1:0] period_counts;
  } out_item_t;

  // One classified request: state after the item, and whether it ends a capture
  typedef struct packed {
    logic             idle;
    logic             fin;
    logic [CNT_W-1:0] high;
    logic [CNT_W-1:0] period;
  } q_entry_t;

endpackage

/* rtl/core/pcdf_front.sv */
`timescale 1ns / 1ps

module pcdf_front import pcdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     echo_mode,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_entry
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RISE1 = 2'd1;
  localparam logic [1:0] PH_FALL  = 2'd2;
  localparam logic [1:0] PH_RISE2 = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic             prev_r, prev_nxt;
  logic [CNT_W-1:0] high_r, high_nxt;
  logic [CNT_W-1:0] period_r, period_nxt;
  logic [CNT_W-1:0] tick_inc;
  logic             rising, falling, fin;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign rising   = in_data.pin_level && !prev_r;
  assign falling  = !in_data.pin_level && prev_r;
  // saturating tick count
  assign tick_inc = (tick_r != CNT_MAX) ? tick_r + 1'b1 : tick_r;

  // Capture sequencing per item
  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    prev_nxt   = prev_r;
    high_nxt   = high_r;
    period_nxt = period_r;
    fin        = 1'b0;
    if (in_data.command == CMD_START) begin
      if (phase_r == PH_IDLE) begin
        phase_nxt = PH_RISE1;
      end
    end else begin
      tick_nxt = tick_inc;
      prev_nxt = in_data.pin_level;
      case (phase_r)
        PH_RISE1: begin
          if (rising) begin
            tick_nxt  = '0;
            phase_nxt = PH_FALL;
          end
        end
        PH_FALL: begin
          if (falling) begin
            high_nxt = tick_inc;
            if (echo_mode) begin
              period_nxt = tick_inc;
              phase_nxt  = PH_IDLE;
              fin        = 1'b1;
            end else begin
              phase_nxt = PH_RISE2;
            end
          end
        end
        PH_RISE2: begin
          if (rising) begin
            period_nxt = tick_inc;
            phase_nxt  = PH_IDLE;
            fin        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    q_entry.idle   = (phase_nxt == PH_IDLE);
    q_entry.fin    = fin;
    q_entry.high   = high_nxt;
    q_entry.period = period_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      prev_r   <= 1'b0;
      high_r   <= '0;
      period_r <= '0;
    end else if (q_push) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      prev_r   <= prev_nxt;
      high_r   <= high_nxt;
      period_r <= period_nxt;
    end
  end

endmodule

/* rtl/core/pcdf_fifo.sv */
`timescale 1ns / 1ps

module pcdf_fifo import pcdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t rdata,
  output logic     full,
  output logic     empty
);

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

/* rtl/core/pcdf_back.sv */
`timescale 1ns / 1ps

module pcdf_back import pcdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [NUM_W-1:0] numerator,
  input  logic             q_empty,
  input  q_entry_t         q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  q_entry_t          ent_r, ent_nxt;
  logic [CNT_W-1:0]  drem_r, drem_nxt;
  logic [NUM_W-1:0]  dquo_r, dquo_nxt;
  logic [DEN_W-1:0]  frem_r, frem_nxt;
  logic [NUM_W-1:0]  fquo_r, fquo_nxt;
  logic [DEN_W-1:0]  fden_r, fden_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic [NUM_W-1:0]  freq_r, freq_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [CNT_W:0]    dtrial, dsub;
  logic [DEN_W:0]    ftrial, fsub;
  logic              dge, fge, out_free;

  function automatic out_item_t mk_out(q_entry_t e, logic [DUTY_W-1:0] duty,
                                       logic [NUM_W-1:0] freq);
    out_item_t o;
    o.ready_res     = e.idle;
    o.duty_percent  = e.idle ? duty : DUTY_NONE;
    o.frequency     = e.idle ? freq : FREQ_NONE;
    o.high_counts   = OUT_CNT_W'(e.high);
    o.period_counts = OUT_CNT_W'(e.period);
    return o;
  endfunction

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // One restoring step of each divider: duty and frequency run side by side
  assign dtrial = {drem_r, dquo_r[NUM_W-1]};
  assign dsub   = dtrial - {1'b0, ent_r.period};
  assign dge    = (dtrial >= {1'b0, ent_r.period});
  assign ftrial = {frem_r, fquo_r[NUM_W-1]};
  assign fsub   = ftrial - {1'b0, fden_r};
  assign fge    = (ftrial >= {1'b0, fden_r});

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ent_nxt       = ent_r;
    drem_nxt      = drem_r;
    dquo_nxt      = dquo_r;
    frem_nxt      = frem_r;
    fquo_nxt      = fquo_r;
    fden_nxt      = fden_r;
    duty_nxt      = duty_r;
    freq_nxt      = freq_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          if (q_entry.fin && (q_entry.period != '0)) begin
            // capture done: load both dividers
            q_pop     = 1'b1;
            ent_nxt   = q_entry;
            drem_nxt  = '0;
            dquo_nxt  = NUM_W'(q_entry.high) * NUM_W'(PCT_SCALE);
            frem_nxt  = '0;
            fquo_nxt  = numerator;
            fden_nxt  = DEN_W'(q_entry.period) * DEN_W'(PRESCALE);
            step_nxt  = '0;
            state_nxt = S_DIV;
          end else if (out_free) begin
            q_pop = 1'b1;
            if (q_entry.fin) begin
              // zero period
              duty_nxt = DUTY_NONE;
              freq_nxt = FREQ_NONE;
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = mk_out(q_entry, duty_nxt, freq_nxt);
          end
        end
      end
      S_DIV: begin
        drem_nxt = dge ? dsub[CNT_W-1:0] : dtrial[CNT_W-1:0];
        dquo_nxt = {dquo_r[NUM_W-2:0], dge};
        frem_nxt = fge ? fsub[DEN_W-1:0] : ftrial[DEN_W-1:0];
        fquo_nxt = {fquo_r[NUM_W-2:0], fge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          // duty saturates at its code range
          duty_nxt      = (dquo_r[NUM_W-1:DUTY_W] != '0) ? DUTY_NONE
                                                          : dquo_r[DUTY_W-1:0];
          freq_nxt      = fquo_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(ent_r, duty_nxt, freq_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      duty_r      <= DUTY_NONE;
      freq_r      <= FREQ_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      duty_r      <= duty_nxt;
      freq_r      <= freq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    drem_r     <= drem_nxt;
    dquo_r     <= dquo_nxt;
    frem_r     <= frem_nxt;
    fquo_r     <= fquo_nxt;
    fden_r     <= fden_nxt;
    out_data_r <= out_data_nxt;
  end

  a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop)
    else $error("queue popped while a division is in flight");

  a_busy_codes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.ready_res) |->
      (out_data_r.duty_percent == DUTY_NONE && out_data_r.frequency == FREQ_NONE))
    else $error("busy result without busy codes");

endmodule

/* rtl/core/pwm_capture_duty_frequency.sv */
// PWM input capture. Each request is a timer tick with the sampled pin level
// or a start command; each one returns exactly one result, in order. A start
// from idle arms the capture: the first rising edge clears the tick counter,
// the falling edge records the high time and, in normal mode, the next rising
// edge records the period (in echo mode the period is the high time). While a
// capture runs the result reports duty 255 and frequency all ones. Rate: one
// request per cycle, unless the queue is full, enters the 4-entry queue between
// the classifying front end and the back end; the back end retires an ordinary
// request once its output is free, but a request that completes a capture with
// a nonzero period holds its two restoring dividers (duty and frequency, one
// quotient bit per cycle each) until both are done. Configuration is a plain
// write port: index 0 is echo mode, index 1 the frequency numerator.
`timescale 1ns / 1ps

module pwm_capture_duty_frequency import pcdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NUM_W-1:0]     cfg_wdata
);

  logic             echo_r, echo_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic             q_push, q_pop, q_full, q_empty;
  q_entry_t         q_wdata, q_rdata;

  // Configuration registers
  always_comb begin
    echo_nxt = echo_r;
    num_nxt  = num_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ECHO_MODE: echo_nxt = cfg_wdata[0];
        CFG_NUMERATOR: num_nxt  = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b0;
      num_r  <= NUMERATOR_RST;
    end else begin
      echo_r <= echo_nxt;
      num_r  <= num_nxt;
    end
  end

  pcdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .echo_mode (echo_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wdata)
  );

  pcdf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  pcdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .numerator (num_r),
    .q_empty   (q_empty),
    .q_entry   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sim/tb_pwm_capture_duty_frequency.sv */
`timescale 1ns / 1ps

module tb_pwm_capture_duty_frequency;
  import pcdf_pkg::*;

  // Capture sequencer states of the predictor
  typedef enum logic [1:0] {
    CAP_IDLE,
    CAP_WAIT_RISE,
    CAP_WAIT_FALL,
    CAP_WAIT_PERIOD
  } cap_state_t;

  // One row of the directed table: a register write or a request
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [NUM_W-1:0]     reg_val;
    in_item_t             rq;
    logic                 typed;
    out_item_t            want;
  } step_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [NUM_W-1:0]     cfg_wdata = '0;

  // Predictor state and register copies
  cap_state_t        cap_state  = CAP_IDLE;
  logic [CNT_W-1:0]  tick_cnt   = '0;
  logic              last_pin   = 1'b0;
  logic [CNT_W-1:0]  high_cnt   = '0;
  logic [CNT_W-1:0]  period_cnt = '0;
  logic [DUTY_W-1:0] duty_val   = DUTY_NONE;
  logic [NUM_W-1:0]  freq_val   = FREQ_NONE;
  logic              echo_on    = 1'b0;
  logic [NUM_W-1:0]  numerator  = NUMERATOR_RST;

  out_item_t   pending_readings[$];
  step_t       directed_plan[$];
  int unsigned items_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  pwm_capture_duty_frequency dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Capture done: back to idle, work out duty and frequency
  function automatic void close_capture();
    logic [63:0] pct;
    cap_state = CAP_IDLE;
    if (period_cnt == '0) begin
      duty_val = DUTY_NONE;
      freq_val = FREQ_NONE;
    end else begin
      pct      = (64'(high_cnt) * 64'(PCT_SCALE)) / 64'(period_cnt);
      duty_val = (pct > 64'd255) ? 8'd255 : pct[DUTY_W-1:0];
      freq_val = NUM_W'(64'(numerator) / (64'(period_cnt) * 64'(PRESCALE)));
    end
  endfunction

  // Advance the predictor by one request and return the reading it gives
  function automatic out_item_t predict_reading(in_item_t rq);
    out_item_t r;
    logic      rising;
    logic      falling;
    if (rq.command == CMD_START) begin
      // start only arms from idle; pin and counter untouched
      if (cap_state == CAP_IDLE) cap_state = CAP_WAIT_RISE;
    end else begin
      rising  = rq.pin_level & ~last_pin;
      falling = ~rq.pin_level & last_pin;
      if (tick_cnt != CNT_MAX) tick_cnt = tick_cnt + 1'b1;
      if (cap_state == CAP_WAIT_RISE && rising) begin
        tick_cnt  = '0;
        cap_state = CAP_WAIT_FALL;
      end else if (cap_state == CAP_WAIT_FALL && falling) begin
        high_cnt = tick_cnt;
        if (echo_on) begin
          period_cnt = high_cnt;
          close_capture();
        end else begin
          cap_state = CAP_WAIT_PERIOD;
        end
      end else if (cap_state == CAP_WAIT_PERIOD && rising) begin
        period_cnt = tick_cnt;
        close_capture();
      end
      last_pin = rq.pin_level;
    end
    r.ready_res     = (cap_state == CAP_IDLE);
    r.duty_percent  = r.ready_res ? duty_val : DUTY_NONE;
    r.frequency     = r.ready_res ? freq_val : FREQ_NONE;
    r.high_counts   = OUT_CNT_W'(high_cnt);
    r.period_counts = OUT_CNT_W'(period_cnt);
    return r;
  endfunction

  function automatic in_item_t make_req(logic cmd, logic pin);
    in_item_t rq;
    rq.command   = cmd;
    rq.pin_level = pin;
    return rq;
  endfunction

  // Table row builders
  function automatic step_t tick_row(logic pin);
    step_t s;
    s    = '0;
    s.rq = make_req(CMD_TICK, pin);
    return s;
  endfunction

  function automatic step_t start_row(logic pin);
    step_t s;
    s    = '0;
    s.rq = make_req(CMD_START, pin);
    return s;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] val);
    step_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // Rows whose reading shows the no-result codes
  function automatic step_t typed_row(step_t s, logic rdy, logic [OUT_CNT_W-1:0] hi,
                                      logic [OUT_CNT_W-1:0] per);
    s.typed              = 1'b1;
    s.want.ready_res     = rdy;
    s.want.duty_percent  = DUTY_NONE;
    s.want.frequency     = FREQ_NONE;
    s.want.high_counts   = hi;
    s.want.period_counts = per;
    return s;
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 99) < 5) ? $urandom_range(13, 300) : $urandom_range(1, 12);
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_reading(out_item_t got);
    out_item_t want;
    if (pending_readings.size() == 0) begin
      note_mismatch("unexpected reading", 64'(got), 64'd0);
      return;
    end
    want = pending_readings.pop_front();
    if (got.ready_res !== want.ready_res)
      note_mismatch("ready_res", 64'(got.ready_res), 64'(want.ready_res));
    if (got.duty_percent !== want.duty_percent)
      note_mismatch("duty_percent", 64'(got.duty_percent), 64'(want.duty_percent));
    if (got.frequency !== want.frequency)
      note_mismatch("frequency", 64'(got.frequency), 64'(want.frequency));
    if (got.high_counts !== want.high_counts)
      note_mismatch("high_counts", 64'(got.high_counts), 64'(want.high_counts));
    if (got.period_counts !== want.period_counts)
      note_mismatch("period_counts", 64'(got.period_counts), 64'(want.period_counts));
  endtask

  // Offer one request, wait for the handshake, then queue its reading
  task automatic send_request(in_item_t rq, logic typed, out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
    predicted = predict_reading(rq);
    pending_readings.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Tick with a little noise: stray starts and pin glitches
  task automatic send_tick(logic pin);
    if ($urandom_range(0, 99) < 3) send_request(make_req(CMD_START, 1'($urandom)), 1'b0, '0);
    send_request(make_req(CMD_TICK, ($urandom_range(0, 99) < 2) ? ~pin : pin), 1'b0, '0);
  endtask

  // Register write once all readings are back and the back end has settled
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ECHO_MODE: echo_on = val[0];
      CFG_NUMERATOR: numerator = val;
      default: ;
    endcase
  endtask

  // Mostly well-formed pulses with random widths, some random requests between
  task automatic run_captures(int unsigned n);
    int unsigned stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 8))
          send_request(make_req(1'($urandom), 1'($urandom)), 1'b0, '0);
      end else begin
        send_request(make_req(CMD_START, 1'($urandom)), 1'b0, '0);
        repeat ($urandom_range(1, 3)) send_tick(1'b0);
        repeat (pick_len()) send_tick(1'b1);
        repeat (pick_len()) send_tick(1'b0);
        send_tick(1'b1);
      end
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Reading monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_reading(out_data);
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [NUM_W-1:0] num_val;

    // Normal mode at reset settings: idle reading, stray starts, one capture
    directed_plan.push_back(typed_row(tick_row(1'b0), 1'b1, 16'd0, 16'd0));
    directed_plan.push_back(typed_row(start_row(1'b1), 1'b0, 16'd0, 16'd0));
    directed_plan.push_back(typed_row(start_row(1'b0), 1'b0, 16'd0, 16'd0));
    directed_plan.push_back(typed_row(tick_row(1'b0), 1'b0, 16'd0, 16'd0));
    directed_plan.push_back(typed_row(tick_row(1'b1), 1'b0, 16'd0, 16'd0));
    directed_plan.push_back(typed_row(tick_row(1'b1), 1'b0, 16'd0, 16'd0));
    directed_plan.push_back(typed_row(tick_row(1'b1), 1'b0, 16'd0, 16'd0));
    directed_plan.push_back(typed_row(start_row(1'b0), 1'b0, 16'd0, 16'd0));
    directed_plan.push_back(typed_row(tick_row(1'b0), 1'b0, 16'd3, 16'd0));
    directed_plan.push_back(typed_row(tick_row(1'b0), 1'b0, 16'd3, 16'd0));
    directed_plan.push_back(tick_row(1'b1));
    // Echo mode, largest numerator, shortest pulse
    directed_plan.push_back(cfg_row(CFG_ECHO_MODE, NUM_W'(1)));
    directed_plan.push_back(cfg_row(CFG_NUMERATOR, '1));
    directed_plan.push_back(typed_row(start_row(1'b1), 1'b0, 16'd3, 16'd5));
    directed_plan.push_back(typed_row(tick_row(1'b0), 1'b0, 16'd3, 16'd5));
    directed_plan.push_back(typed_row(tick_row(1'b1), 1'b0, 16'd3, 16'd5));
    directed_plan.push_back(tick_row(1'b0));
    // Echo mode with a zero numerator
    directed_plan.push_back(cfg_row(CFG_NUMERATOR, '0));
    directed_plan.push_back(typed_row(start_row(1'b0), 1'b0, 16'd1, 16'd1));
    directed_plan.push_back(typed_row(tick_row(1'b1), 1'b0, 16'd1, 16'd1));
    directed_plan.push_back(typed_row(tick_row(1'b1), 1'b0, 16'd1, 16'd1));
    directed_plan.push_back(tick_row(1'b0));
    // Normal mode, smallest numerator, shortest period
    directed_plan.push_back(cfg_row(CFG_ECHO_MODE, NUM_W'(0)));
    directed_plan.push_back(cfg_row(CFG_NUMERATOR, NUM_W'(1)));
    directed_plan.push_back(typed_row(start_row(1'b1), 1'b0, 16'd2, 16'd2));
    directed_plan.push_back(typed_row(tick_row(1'b0), 1'b0, 16'd2, 16'd2));
    directed_plan.push_back(typed_row(tick_row(1'b1), 1'b0, 16'd2, 16'd2));
    directed_plan.push_back(typed_row(tick_row(1'b0), 1'b0, 16'd1, 16'd2));
    directed_plan.push_back(tick_row(1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    snd_idle_pct = 26;
    rcv_idle_pct = 73;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg)
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      else
        send_request(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].want);
    end

    // Random pulses under three idling profiles, two register settings each
    for (int p = 0; p < 3; p++) begin
      snd_idle_pct = (p == 0) ? 26 : (p == 1) ? 73 : 0;
      rcv_idle_pct = (p == 0) ? 73 : (p == 1) ? 26 : 0;
      for (int s = 0; s < 2; s++) begin
        case (2 * p + s)
          0: num_val = '1;
          1: num_val = NUM_W'(1);
          2: num_val = NUMERATOR_RST;
          3: num_val = NUM_W'($urandom_range(1, 1000));
          default: num_val = $urandom;
        endcase
        write_reg(CFG_ECHO_MODE, NUM_W'(s));
        write_reg(CFG_NUMERATOR, num_val);
        run_captures(75);
      end
    end

    // Drain, then let any stray reading show up
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* pwm_capture_duty_frequency.f */
rtl/core/pcdf_pkg.sv
rtl/core/pcdf_front.sv
rtl/core/pcdf_fifo.sv
rtl/core/pcdf_back.sv
rtl/core/pwm_capture_duty_frequency.sv
sim/tb_pwm_capture_duty_frequency.sv
